>>> rtl/grid_maze_backtracker_top_defines.svh
// assertion macros for the grid maze backtracker
`ifndef GRID_MAZE_BACKTRACKER_TOP_DEFINES_SVH
`define GRID_MAZE_BACKTRACKER_TOP_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define GMB_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define GMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gmb_pkg.sv
// shared types, constants and helper functions of the grid maze backtracker
package gmb_pkg;

    // grid limits
    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 32;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

    // field and register widths
    localparam int CELL_W    = 10;
    localparam int COUNT_W   = CELL_W + 1;
    localparam int DIM_W     = 6;
    localparam int RAND_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int SCAN_W    = 3;

    localparam logic [DIM_W-1:0]   COLS_RESET = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0]   ROWS_RESET = DIM_W'(MAX_ROWS);
    localparam logic [COUNT_W-1:0] STACK_FULL = COUNT_W'(CELL_COUNT);
    localparam logic [CELL_W-1:0]  CELL_LAST  = CELL_W'(CELL_COUNT - 1);
    localparam logic [SCAN_W-1:0]  SCAN_END   = SCAN_W'(4);

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

    typedef enum logic [1:0] {
        EV_STARTED   = 2'd0,
        EV_CARVED    = 2'd1,
        EV_BACKTRACK = 2'd2,
        EV_FINISHED  = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        DIR_EAST  = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_WEST  = 2'd2,
        DIR_NORTH = 2'd3
    } direction_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_SCAN,
        ST_PICK,
        ST_POP
    } state_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [CELL_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [CELL_W-1:0] quotient;
        logic [DIM_W-1:0]  remainder;
    } div_rsp_t;

    // zero counts as one, anything above the maximum counts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        priority if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // rand modulo candidate count (1..4), mod 3 by summing base-4 digits
    function automatic logic [1:0] pick_index(input logic [RAND_W-1:0] rnd,
                                              input logic [2:0] count);
        logic [3:0] s;
        logic [2:0] t;
        logic [2:0] m3;
        logic [1:0] r;
        s = {2'b00, rnd[1:0]} + {2'b00, rnd[3:2]} + {2'b00, rnd[5:4]} + {2'b00, rnd[7:6]};
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
        priority if (t >= 3'd6)
            m3 = t - 3'd6;
        else if (t >= 3'd3)
            m3 = t - 3'd3;
        else
            m3 = t;
        unique case (count)
            3'd2:    r = {1'b0, rnd[0]};
            3'd3:    r = m3[1:0];
            3'd4:    r = rnd[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/gmb_if.sv
// handshake channels for step requests and walk events
interface gmb_step_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [gmb_pkg::RAND_W-1:0]  rand_value;

    modport source (output valid, output req_type, output rand_value, input ready);
    modport sink   (input valid, input req_type, input rand_value, output ready);
endinterface

interface gmb_event_if;
    logic                        valid;
    logic                        ready;
    gmb_pkg::event_kind_t        event_kind;
    logic [gmb_pkg::CELL_W-1:0]  from_cell;
    logic [gmb_pkg::CELL_W-1:0]  to_cell;
    gmb_pkg::direction_t         direction;

    modport source (output valid, output event_kind, output from_cell, output to_cell,
                    output direction, input ready);
    modport sink   (input valid, input event_kind, input from_cell, input to_cell,
                    input direction, output ready);
endinterface

>>> rtl/gmb_ram.sv
// generic single-write single-read memory with registered read data
module gmb_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/gmb_divider.sv
// iterative restoring divider, one quotient bit per cycle
module gmb_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gmb_pkg::div_req_t req,
    output gmb_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(gmb_pkg::CELL_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [gmb_pkg::CELL_W-1:0]  quo_reg, quo_next;
    logic [gmb_pkg::DIM_W-1:0]   rem_reg, rem_next;
    logic [gmb_pkg::DIM_W-1:0]   dsr_reg, dsr_next;
    logic [gmb_pkg::DIM_W:0]     trial;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // shift, trial subtract, restore
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[gmb_pkg::CELL_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gmb_pkg::CELL_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = gmb_pkg::DIM_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[gmb_pkg::CELL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gmb_pkg::DIM_W-1:0];
                quo_next = {quo_reg[gmb_pkg::CELL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/grid_maze_backtracker_top.sv
// top level of the grid maze backtracker: sequencer, visited map and path stack
//
//   channel     dir   handshake          payload
//   step_in     in    valid / ready      req_type, rand_value
//   event_out   out   valid / ready      event_kind, from_cell, to_cell, direction
//   cfg         in    cfg_wr_en          cfg_index, cfg_data
//
// start item: a sweep over the visited map clearing one bit a cycle and marking cell 0
// step item, walk active: the shared divider gives row and column, then the neighbours
// are scanned through the one visited-map read port, then a carve, backtrack pop or finish
// step item, walk finished or never started: reports finished with no divide or scan
// reset clears control state only; the visited map is swept by each start item
// step_in is ready only when idle and the event register is empty
`include "grid_maze_backtracker_top_defines.svh"

module grid_maze_backtracker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    gmb_step_if.sink                      step_in,
    gmb_event_if.source                   event_out,
    input  logic                          cfg_wr_en,
    input  logic [gmb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmb_pkg::DIM_W-1:0]     cfg_data
);

    localparam int CW = gmb_pkg::CELL_W;

    gmb_pkg::state_t             state_reg, state_next;
    logic [gmb_pkg::DIM_W-1:0]   cols_cfg_reg, rows_cfg_reg;
    logic [CW-1:0]               cur_reg, cur_next;
    logic [gmb_pkg::COUNT_W-1:0] sp_reg, sp_next;
    logic                        done_reg, done_next;
    logic [gmb_pkg::RAND_W-1:0]  rnd_reg, rnd_next;
    logic [CW-1:0]               clr_reg, clr_next;
    logic [CW-1:0]               row_reg, row_next;
    logic [gmb_pkg::DIM_W-1:0]   col_reg, col_next;
    logic [gmb_pkg::SCAN_W-1:0]  scan_reg, scan_next;
    logic                        pend_valid_reg, pend_valid_next;
    gmb_pkg::direction_t         pend_dir_reg, pend_dir_next;
    logic [CW-1:0]               pend_cell_reg, pend_cell_next;
    logic [CW-1:0]               cand_cell_reg [4];
    logic [CW-1:0]               cand_cell_next [4];
    gmb_pkg::direction_t         cand_dir_reg [4];
    gmb_pkg::direction_t         cand_dir_next [4];
    logic [2:0]                  cand_cnt_reg, cand_cnt_next;

    logic                        out_valid_reg, out_valid_next;
    gmb_pkg::event_kind_t        out_kind_reg, out_kind_next;
    logic [CW-1:0]               out_from_reg, out_from_next;
    logic [CW-1:0]               out_to_reg, out_to_next;
    gmb_pkg::direction_t         out_dir_reg, out_dir_next;

    logic [gmb_pkg::DIM_W-1:0]   cols, rows;
    logic [CW:0]                 c_x, r_x, nc_x, nr_x, idx_x;
    logic                        nbr_ok;
    gmb_pkg::direction_t         scan_dir;
    logic [gmb_pkg::COUNT_W-1:0] sp_dec;
    logic [1:0]                  pick;
    logic                        accept;

    gmb_pkg::div_req_t           div_req;
    gmb_pkg::div_rsp_t           div_rsp;

    logic                        vis_wr_en, vis_wr_data, vis_rd_en, vis_rd_data;
    logic [CW-1:0]               vis_wr_addr, vis_rd_addr;
    logic                        stk_wr_en, stk_rd_en;
    logic [CW-1:0]               stk_wr_addr, stk_rd_addr, stk_rd_data;

    // shared divider for row and column of the current cell
    gmb_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // visited map, one bit per cell
    gmb_ram #(.WIDTH(1), .DEPTH(gmb_pkg::CELL_COUNT)) u_visited (
        .clk     (clk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_wr_data),
        .rd_en   (vis_rd_en),
        .rd_addr (vis_rd_addr),
        .rd_data (vis_rd_data)
    );

    // path stack of cells left behind
    gmb_ram #(.WIDTH(CW), .DEPTH(gmb_pkg::CELL_COUNT)) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (cur_reg),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= gmb_pkg::COLS_RESET;
            rows_cfg_reg <= gmb_pkg::ROWS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gmb_pkg::REG_NUM_COLS: cols_cfg_reg <= cfg_data;
                gmb_pkg::REG_NUM_ROWS: rows_cfg_reg <= cfg_data;
                default:               cols_cfg_reg <= cols_cfg_reg;
            endcase
        end
    end

    // control and walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gmb_pkg::ST_IDLE;
            cur_reg        <= '0;
            sp_reg         <= '0;
            done_reg       <= 1'b1;
            clr_reg        <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            cand_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            sp_reg         <= sp_next;
            done_reg       <= done_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            cand_cnt_reg   <= cand_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rnd_reg       <= rnd_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        pend_dir_reg  <= pend_dir_next;
        pend_cell_reg <= pend_cell_next;
        cand_cell_reg <= cand_cell_next;
        cand_dir_reg  <= cand_dir_next;
        out_kind_reg  <= out_kind_next;
        out_from_reg  <= out_from_next;
        out_to_reg    <= out_to_next;
        out_dir_reg   <= out_dir_next;
    end

    // grid in use and neighbour of the scan position
    always_comb
    begin
        cols     = gmb_pkg::clamp_dim(cols_cfg_reg, gmb_pkg::COLS_RESET);
        rows     = gmb_pkg::clamp_dim(rows_cfg_reg, gmb_pkg::ROWS_RESET);
        c_x      = (CW + 1)'(col_reg);
        r_x      = {1'b0, row_reg};
        nc_x     = (CW + 1)'(cols);
        nr_x     = (CW + 1)'(rows);
        scan_dir = gmb_pkg::direction_t'(scan_reg[1:0]);
        unique case (scan_dir)
            gmb_pkg::DIR_EAST:
            begin
                nbr_ok = (c_x + (CW + 1)'(1) < nc_x) && (r_x < nr_x);
                idx_x  = {1'b0, cur_reg} + (CW + 1)'(1);
            end
            gmb_pkg::DIR_SOUTH:
            begin
                nbr_ok = (r_x + (CW + 1)'(1) < nr_x) && (c_x < nc_x);
                idx_x  = {1'b0, cur_reg} + nc_x;
            end
            gmb_pkg::DIR_WEST:
            begin
                nbr_ok = (c_x != '0) && (c_x - (CW + 1)'(1) < nc_x) && (r_x < nr_x);
                idx_x  = {1'b0, cur_reg} - (CW + 1)'(1);
            end
            default:
            begin
                nbr_ok = (r_x != '0) && (r_x - (CW + 1)'(1) < nr_x) && (c_x < nc_x);
                idx_x  = {1'b0, cur_reg} - nc_x;
            end
        endcase
        nbr_ok = nbr_ok && (idx_x < (CW + 1)'(gmb_pkg::CELL_COUNT));
    end

    assign sp_dec = sp_reg - gmb_pkg::COUNT_W'(1);
    assign pick   = gmb_pkg::pick_index(rnd_reg, cand_cnt_reg);
    assign accept = step_in.valid && step_in.ready;

    // sequencer: next state, memory ports and event register
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        sp_next         = sp_reg;
        done_next       = done_reg;
        rnd_next        = rnd_reg;
        clr_next        = clr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_dir_next   = pend_dir_reg;
        pend_cell_next  = pend_cell_reg;
        cand_cell_next  = cand_cell_reg;
        cand_dir_next   = cand_dir_reg;
        cand_cnt_next   = cand_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_from_next   = out_from_reg;
        out_to_next     = out_to_reg;
        out_dir_next    = out_dir_reg;

        div_req.start    = 1'b0;
        div_req.dividend = cur_reg;
        div_req.divisor  = cols;
        vis_wr_en        = 1'b0;
        vis_wr_addr      = clr_reg;
        vis_wr_data      = 1'b0;
        vis_rd_en        = 1'b0;
        vis_rd_addr      = idx_x[CW-1:0];
        stk_wr_en        = 1'b0;
        stk_wr_addr      = sp_reg[CW-1:0];
        stk_rd_en        = 1'b0;
        stk_rd_addr      = sp_dec[CW-1:0];

        // event taken downstream
        if (out_valid_reg && event_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            gmb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next = step_in.rand_value;
                    priority if (step_in.req_type == gmb_pkg::REQ_START)
                    begin
                        clr_next   = '0;
                        state_next = gmb_pkg::ST_CLEAR;
                    end
                    else if (done_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = gmb_pkg::EV_FINISHED;
                        out_from_next  = cur_reg;
                        out_to_next    = cur_reg;
                        out_dir_next   = gmb_pkg::DIR_EAST;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = gmb_pkg::ST_DIV;
                    end
                end
            end

            // sweep the visited map, leaving only cell 0 marked
            gmb_pkg::ST_CLEAR:
            begin
                vis_wr_en   = 1'b1;
                vis_wr_data = (clr_reg == '0);
                clr_next    = clr_reg + CW'(1);
                if (clr_reg == gmb_pkg::CELL_LAST)
                begin
                    sp_next        = '0;
                    cur_next       = '0;
                    done_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_kind_next  = gmb_pkg::EV_STARTED;
                    out_from_next  = '0;
                    out_to_next    = '0;
                    out_dir_next   = gmb_pkg::DIR_EAST;
                    state_next     = gmb_pkg::ST_IDLE;
                end
            end

            gmb_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    row_next        = div_rsp.quotient;
                    col_next        = div_rsp.remainder;
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                    cand_cnt_next   = '0;
                    state_next      = gmb_pkg::ST_SCAN;
                end
            end

            // read one neighbour bit per cycle, judge the previous one
            gmb_pkg::ST_SCAN:
            begin
                if (pend_valid_reg && !vis_rd_data)
                begin
                    cand_cell_next[cand_cnt_reg[1:0]] = pend_cell_reg;
                    cand_dir_next[cand_cnt_reg[1:0]]  = pend_dir_reg;
                    cand_cnt_next                     = cand_cnt_reg + 3'd1;
                end
                if (scan_reg == gmb_pkg::SCAN_END)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = gmb_pkg::ST_PICK;
                end
                else
                begin
                    vis_rd_en       = nbr_ok;
                    pend_valid_next = nbr_ok;
                    pend_dir_next   = scan_dir;
                    pend_cell_next  = idx_x[CW-1:0];
                    scan_next       = scan_reg + gmb_pkg::SCAN_W'(1);
                end
            end

            gmb_pkg::ST_PICK:
            begin
                priority if (cand_cnt_reg != '0)
                begin
                    if (sp_reg < gmb_pkg::STACK_FULL)
                    begin
                        stk_wr_en = 1'b1;
                        sp_next   = sp_reg + gmb_pkg::COUNT_W'(1);
                    end
                    vis_wr_en      = 1'b1;
                    vis_wr_addr    = cand_cell_reg[pick];
                    vis_wr_data    = 1'b1;
                    cur_next       = cand_cell_reg[pick];
                    out_valid_next = 1'b1;
                    out_kind_next  = gmb_pkg::EV_CARVED;
                    out_from_next  = cur_reg;
                    out_to_next    = cand_cell_reg[pick];
                    out_dir_next   = cand_dir_reg[pick];
                    state_next     = gmb_pkg::ST_IDLE;
                end
                else if (sp_reg != '0)
                begin
                    stk_rd_en  = 1'b1;
                    sp_next    = sp_dec;
                    state_next = gmb_pkg::ST_POP;
                end
                else
                begin
                    done_next      = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = gmb_pkg::EV_FINISHED;
                    out_from_next  = cur_reg;
                    out_to_next    = cur_reg;
                    out_dir_next   = gmb_pkg::DIR_EAST;
                    state_next     = gmb_pkg::ST_IDLE;
                end
            end

            gmb_pkg::ST_POP:
            begin
                cur_next       = stk_rd_data;
                out_valid_next = 1'b1;
                out_kind_next  = gmb_pkg::EV_BACKTRACK;
                out_from_next  = cur_reg;
                out_to_next    = stk_rd_data;
                out_dir_next   = gmb_pkg::DIR_EAST;
                state_next     = gmb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = gmb_pkg::ST_IDLE;
            end
        endcase
    end

    // channel outputs
    assign step_in.ready        = (state_reg == gmb_pkg::ST_IDLE) && !out_valid_reg;
    assign event_out.valid      = out_valid_reg;
    assign event_out.event_kind = out_kind_reg;
    assign event_out.from_cell  = out_from_reg;
    assign event_out.to_cell    = out_to_reg;
    assign event_out.direction  = out_dir_reg;

    // checks
    `GMB_ASSERT_IMP(a_ready_needs_empty_out, step_in.ready, !event_out.valid,
        "ready while event pending")
    `GMB_ASSERT_NEXT(a_busy_after_accept, step_in.valid && step_in.ready, !step_in.ready,
        "ready right after accept")
    `GMB_ASSERT_IMP(a_carve_moves,
        event_out.valid && (event_out.event_kind == gmb_pkg::EV_CARVED),
        event_out.from_cell != event_out.to_cell, "carve to same cell")
    `GMB_ASSERT_IMP(a_finish_sets_done,
        event_out.valid && (event_out.event_kind == gmb_pkg::EV_FINISHED),
        done_reg, "finished event while walk active")
    `GMB_ASSERT_HOLDS(a_stack_bound, sp_reg <= gmb_pkg::STACK_FULL, "stack count overflow")

endmodule

>>> dv/grid_maze_backtracker_top_tb.sv
// self-checking testbench for the grid maze backtracker top level
`timescale 1ns / 100ps

module grid_maze_backtracker_top_tb;

    // one walk event as the block reports it
    typedef struct packed {
        gmb_pkg::event_kind_t       kind;
        logic [gmb_pkg::CELL_W-1:0] from_cell;
        logic [gmb_pkg::CELL_W-1:0] to_cell;
        gmb_pkg::direction_t        dir;
    } walk_event_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [gmb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gmb_pkg::DIM_W-1:0]     cfg_data;

    gmb_step_if  step_ch ();
    gmb_event_if event_ch ();

    grid_maze_backtracker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_in   (step_ch),
        .event_out (event_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // walk state mirrored by the predictor
    logic [gmb_pkg::DIM_W-1:0]  grid_cols;
    logic [gmb_pkg::DIM_W-1:0]  grid_rows;
    bit                         visited_cells [gmb_pkg::CELL_COUNT];
    logic [gmb_pkg::CELL_W-1:0] path_cells [gmb_pkg::CELL_COUNT];
    int                         path_depth;
    logic [gmb_pkg::CELL_W-1:0] walk_pos;
    bit                         walk_over;

    walk_event_t pending_events [$];

    // bookkeeping
    int n_errors;
    int n_items;
    int n_cfg_writes;
    int n_seen [4];
    bit src_quiet;
    bit sink_quiet;
    int sink_hold_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("timeout: walk events stopped arriving, %0d still pending",
                 pending_events.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // zero counts as one, above the maximum counts as the maximum
    function automatic int dim_in_use(input logic [gmb_pkg::DIM_W-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // expected event for one request, updates the mirrored walk
    function automatic walk_event_t predict_walk_event(input logic req,
                                                       input logic [gmb_pkg::RAND_W-1:0] rnd);
        walk_event_t         ev;
        int                  cols;
        int                  rows;
        int                  row;
        int                  col;
        int                  nr;
        int                  nc;
        int                  idx;
        int                  n_cand;
        int                  pick;
        bit                  ok;
        int                  cand_cell [4];
        gmb_pkg::direction_t cand_dir [4];

        ev = '{gmb_pkg::EV_STARTED, '0, '0, gmb_pkg::DIR_EAST};
        cols = dim_in_use(grid_cols, gmb_pkg::MAX_COLS);
        rows = dim_in_use(grid_rows, gmb_pkg::MAX_ROWS);

        // restart at cell 0
        if (req == gmb_pkg::REQ_START)
        begin
            visited_cells = '{default: 1'b0};
            path_depth = 0;
            walk_pos = '0;
            visited_cells[0] = 1'b1;
            walk_over = 1'b0;
            return ev;
        end

        // idle or finished walk reports finished again
        if (walk_over)
        begin
            ev.kind = gmb_pkg::EV_FINISHED;
            ev.from_cell = walk_pos;
            ev.to_cell = walk_pos;
            return ev;
        end

        // collect unvisited in-grid neighbours, east south west north
        row = int'(walk_pos) / cols;
        col = int'(walk_pos) % cols;
        n_cand = 0;
        for (int d = 0; d < 4; d++)
        begin
            nr = row;
            nc = col;
            case (gmb_pkg::direction_t'(d))
                gmb_pkg::DIR_EAST:
                begin
                    ok = (col + 1 < cols) && (row < rows);
                    nc = col + 1;
                end
                gmb_pkg::DIR_SOUTH:
                begin
                    ok = (row + 1 < rows) && (col < cols);
                    nr = row + 1;
                end
                gmb_pkg::DIR_WEST:
                begin
                    ok = (col > 0) && (col - 1 < cols) && (row < rows);
                    nc = col - 1;
                end
                default:
                begin
                    ok = (row > 0) && (row - 1 < rows) && (col < cols);
                    nr = row - 1;
                end
            endcase
            if (ok)
            begin
                idx = nr * cols + nc;
                if (idx < gmb_pkg::CELL_COUNT && !visited_cells[idx])
                begin
                    cand_cell[n_cand] = idx;
                    cand_dir[n_cand] = gmb_pkg::direction_t'(d);
                    n_cand++;
                end
            end
        end

        // carve to the chosen neighbour
        if (n_cand > 0)
        begin
            pick = int'(rnd) % n_cand;
            if (path_depth < gmb_pkg::CELL_COUNT)
            begin
                path_cells[path_depth] = walk_pos;
                path_depth++;
            end
            ev.kind = gmb_pkg::EV_CARVED;
            ev.from_cell = walk_pos;
            ev.to_cell = gmb_pkg::CELL_W'(cand_cell[pick]);
            ev.dir = cand_dir[pick];
            visited_cells[cand_cell[pick]] = 1'b1;
            walk_pos = gmb_pkg::CELL_W'(cand_cell[pick]);
            return ev;
        end

        // dead end: pop back along the path
        if (path_depth > 0)
        begin
            ev.kind = gmb_pkg::EV_BACKTRACK;
            ev.from_cell = walk_pos;
            path_depth--;
            walk_pos = path_cells[path_depth];
            ev.to_cell = walk_pos;
            return ev;
        end

        // empty path: walk complete
        walk_over = 1'b1;
        ev.kind = gmb_pkg::EV_FINISHED;
        ev.from_cell = walk_pos;
        ev.to_cell = walk_pos;
        return ev;
    endfunction

    // send one request item, with random gaps in front
    task automatic send_request(input logic req, input logic [gmb_pkg::RAND_W-1:0] rnd);
        while (!src_quiet && $urandom_range(99) < 18)
        begin
            step_ch.valid = 1'b0;
            @(negedge clk);
        end
        step_ch.valid = 1'b1;
        step_ch.req_type = req;
        step_ch.rand_value = rnd;
        do
            @(posedge clk);
        while (step_ch.ready !== 1'b1);
        pending_events.push_back(predict_walk_event(req, rnd));
        n_items++;
        @(negedge clk);
    endtask

    // stop sending and wait for every pending event
    task automatic wait_all_events();
        step_ch.valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic write_grid_reg(input logic [gmb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [gmb_pkg::DIM_W-1:0] value);
        wait_all_events();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == gmb_pkg::REG_NUM_COLS)
            grid_cols = value;
        else
            grid_rows = value;
        n_cfg_writes++;
    endtask

    // mostly tiny grids, sometimes the limits and out-of-range values
    function automatic logic [gmb_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return gmb_pkg::DIM_W'(gmb_pkg::MAX_COLS);
            3:       return gmb_pkg::DIM_W'($urandom_range(33, 62));
            4, 5:    return gmb_pkg::DIM_W'($urandom_range(63));
            default: return gmb_pkg::DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // event receiver with random stalls and forced hold-offs
    initial
    begin
        event_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                event_ch.ready = 1'b0;
                sink_hold_cycles--;
            end
            else if (!sink_quiet && $urandom_range(99) < 18)
                event_ch.ready = 1'b0;
            else
                event_ch.ready = 1'b1;
        end
    end

    // compare each accepted event with the oldest expectation
    always @(posedge clk)
    begin : check_events
        walk_event_t exp_ev;
        if (rst_n === 1'b1 && event_ch.valid === 1'b1 && event_ch.ready === 1'b1)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected event kind %0d from %0d to %0d",
                                          event_ch.event_kind, event_ch.from_cell,
                                          event_ch.to_cell));
            else
            begin
                exp_ev = pending_events.pop_front();
                n_seen[exp_ev.kind]++;
                if (event_ch.event_kind !== exp_ev.kind)
                    report_mismatch($sformatf("event_kind got %0d exp %0d",
                                              event_ch.event_kind, exp_ev.kind));
                if (event_ch.from_cell !== exp_ev.from_cell)
                    report_mismatch($sformatf("from_cell got %0d exp %0d",
                                              event_ch.from_cell, exp_ev.from_cell));
                if (event_ch.to_cell !== exp_ev.to_cell)
                    report_mismatch($sformatf("to_cell got %0d exp %0d",
                                              event_ch.to_cell, exp_ev.to_cell));
                if (event_ch.direction !== exp_ev.dir)
                    report_mismatch($sformatf("direction got %0d exp %0d",
                                              event_ch.direction, exp_ev.dir));
            end
        end
    end

    // steps before any start report finished at cell 0
    task automatic test_idle_steps();
        send_request(gmb_pkg::REQ_STEP, 8'hFF);
        send_request(gmb_pkg::REQ_STEP, 8'h00);
    endtask

    // zero and oversized dimensions are clamped
    task automatic test_grid_clamp();
        write_grid_reg(gmb_pkg::REG_NUM_COLS, '0);
        write_grid_reg(gmb_pkg::REG_NUM_ROWS, '0);
        send_request(gmb_pkg::REQ_START, 8'h00);
        send_request(gmb_pkg::REQ_STEP, 8'h5A);
        send_request(gmb_pkg::REQ_STEP, 8'hA5);
        write_grid_reg(gmb_pkg::REG_NUM_COLS, '1);
        write_grid_reg(gmb_pkg::REG_NUM_ROWS, '1);
        send_request(gmb_pkg::REQ_START, 8'hFF);
        send_request(gmb_pkg::REQ_STEP, 8'h00);
        send_request(gmb_pkg::REQ_STEP, 8'hFF);
        send_request(gmb_pkg::REQ_STEP, 8'h55);
        send_request(gmb_pkg::REQ_STEP, 8'hAA);
    endtask

    // complete walk of a 2x2 grid: carves, backtracks, finish
    task automatic test_small_walk();
        write_grid_reg(gmb_pkg::REG_NUM_COLS, gmb_pkg::DIM_W'(2));
        write_grid_reg(gmb_pkg::REG_NUM_ROWS, gmb_pkg::DIM_W'(2));
        send_request(gmb_pkg::REQ_START, 8'h00);
        repeat (7)
            send_request(gmb_pkg::REQ_STEP, 8'h00);
    endtask

    // shrink the grid in the middle of a walk
    task automatic test_resize_mid_walk();
        write_grid_reg(gmb_pkg::REG_NUM_COLS, gmb_pkg::DIM_W'(4));
        write_grid_reg(gmb_pkg::REG_NUM_ROWS, gmb_pkg::DIM_W'(4));
        send_request(gmb_pkg::REQ_START, 8'h00);
        repeat (3)
            send_request(gmb_pkg::REQ_STEP, gmb_pkg::RAND_W'($urandom_range(255)));
        write_grid_reg(gmb_pkg::REG_NUM_COLS, gmb_pkg::DIM_W'(2));
        repeat (3)
            send_request(gmb_pkg::REQ_STEP, gmb_pkg::RAND_W'($urandom_range(255)));
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        write_grid_reg(gmb_pkg::REG_NUM_COLS, gmb_pkg::DIM_W'(3));
        write_grid_reg(gmb_pkg::REG_NUM_ROWS, gmb_pkg::DIM_W'(3));
        send_request(gmb_pkg::REQ_START, gmb_pkg::RAND_W'($urandom_range(255)));
        // let the map sweep finish so the hold-off meets a waiting event
        wait_all_events();
        src_quiet = 1'b1;
        sink_hold_cycles = 400;
        repeat (12)
            send_request(gmb_pkg::REQ_STEP, gmb_pkg::RAND_W'($urandom_range(255)));
        // sender pauses until the backlog has drained
        wait_all_events();
        src_quiet = 1'b0;
    endtask

    // random walks, with occasional resizes and restarts in the middle
    task automatic test_random_walks();
        int                        n_walks;
        int                        n_steps;
        int                        cells;
        int                        split;
        logic [gmb_pkg::DIM_W-1:0] new_cols;
        logic [gmb_pkg::DIM_W-1:0] new_rows;
        n_walks = 0;
        while (n_items < 1100)
        begin
            // a run of walks with no idling on either side
            src_quiet = (n_walks >= 8 && n_walks < 14);
            sink_quiet = src_quiet;
            new_cols = pick_dim();
            new_rows = pick_dim();
            write_grid_reg(gmb_pkg::REG_NUM_COLS, new_cols);
            write_grid_reg(gmb_pkg::REG_NUM_ROWS, new_rows);
            send_request(gmb_pkg::REQ_START, gmb_pkg::RAND_W'($urandom_range(255)));
            cells = dim_in_use(new_cols, gmb_pkg::MAX_COLS)
                    * dim_in_use(new_rows, gmb_pkg::MAX_ROWS);
            n_steps = 2 * cells + $urandom_range(2);
            if (n_steps > 90)
                n_steps = $urandom_range(40, 90);
            split = ($urandom_range(9) == 0) ? $urandom_range(1, n_steps) : 0;
            for (int i = 0; i < n_steps; i++)
            begin
                if (split != 0 && i == split)
                    write_grid_reg(gmb_pkg::CFG_IDX_W'($urandom_range(1)), pick_dim());
                if ($urandom_range(49) == 0)
                    send_request(gmb_pkg::REQ_START, gmb_pkg::RAND_W'($urandom_range(255)));
                else
                    send_request(gmb_pkg::REQ_STEP, gmb_pkg::RAND_W'($urandom_range(255)));
            end
            n_walks++;
        end
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = gmb_pkg::REG_NUM_COLS;
        cfg_data = '0;
        step_ch.valid = 1'b0;
        step_ch.req_type = gmb_pkg::REQ_START;
        step_ch.rand_value = '0;
        grid_cols = gmb_pkg::COLS_RESET;
        grid_rows = gmb_pkg::ROWS_RESET;
        visited_cells = '{default: 1'b0};
        path_depth = 0;
        walk_pos = '0;
        walk_over = 1'b1;
        n_errors = 0;
        n_items = 0;
        n_cfg_writes = 0;
        n_seen = '{default: 0};
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        sink_hold_cycles = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_steps();
        test_grid_clamp();
        test_small_walk();
        test_resize_mid_walk();
        test_backpressure();
        test_random_walks();

        wait_all_events();
        repeat (40) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

        $display("covered %0d request items and %0d grid register writes, grids 1x1 to 32x32",
                 n_items, n_cfg_writes);
        $display("events checked: %0d started, %0d carved, %0d backtracked, %0d finished",
                 n_seen[gmb_pkg::EV_STARTED], n_seen[gmb_pkg::EV_CARVED],
                 n_seen[gmb_pkg::EV_BACKTRACK], n_seen[gmb_pkg::EV_FINISHED]);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
